>>> src/tot_pkg.sv
// ----------------------------------------------------------------------------
// tot_pkg: shared types and constants for the task overrun timer table
//
// Action codes, status codes, the default table size and the structs that
// carry entry reads and entry updates between the control and the store.
// ----------------------------------------------------------------------------
package tot_pkg;

	// default number of tasks held by the table (ids 1..MAX_TASKS_DEF)
	localparam int MAX_TASKS_DEF = 64;

	// fixed field widths
	localparam int ACT_W  = 3;
	localparam int ID_W   = 8;
	localparam int CUR_W  = 7;
	localparam int TVAL_W = 31;
	localparam int TIME_W = 32;
	localparam int TAG_W  = 32;
	localparam int ATTR_W = 16;

	// action codes
	localparam logic [ACT_W-1:0] ACT_DEFINE = 3'd0;
	localparam logic [ACT_W-1:0] ACT_START  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_STOP   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_REFER  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_TICK   = 3'd4;

	// status codes
	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_BAD_ID = 1'b1;

	// update of one entry, addressed by the item in the compute stage
	typedef struct packed {
		logic [ID_W-1:0]   addr;
		logic              time_we;
		logic [TIME_W-1:0] time_wd;
		logic              hnd_we;
		logic [TAG_W-1:0]  tag_wd;
		logic [ATTR_W-1:0] attr_wd;
		logic              run_set;
		logic              run_clr;
	} entry_wr_t;

	// contents of the entry at the compute stage address
	typedef struct packed {
		logic              run;
		logic              time_vld;
		logic [TIME_W-1:0] time_rd;
		logic              hnd_vld;
		logic [TAG_W-1:0]  tag_rd;
		logic [ATTR_W-1:0] attr_rd;
	} entry_rd_t;

endpackage

>>> src/task_overrun_timer_table.sv
// ----------------------------------------------------------------------------
// task_overrun_timer_table: per-task overrun timers with expiry events
//
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | action, task_id, current_task,
//         |           |                      | time_value, handler_tag,
//         |           |                      | handler_attr
// out     | output    | out_valid / out_ready| status, running, remaining,
//         |           |                      | expired, expired_task,
//         |           |                      | expired_handler
//
// One beat in per cycle while the output is not stalled, one result beat
// per input beat: the accepting edge loads the compute stage and the entry
// memory read register, then one subtract and compare updates the entry and
// fills the output register as the beat leaves the compute stage.
// Reset clears run flags and entry valid bits at once; no clearing pass.
// A stalled output holds the result; the compute stage still takes one beat.
// ----------------------------------------------------------------------------
module task_overrun_timer_table #(
	parameter int MAX_TASKS = tot_pkg::MAX_TASKS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [tot_pkg::ACT_W-1:0]          action,
	input  logic [tot_pkg::ID_W-1:0]           task_id,
	input  logic [tot_pkg::CUR_W-1:0]          current_task,
	input  logic [tot_pkg::TVAL_W-1:0]         time_value,
	input  logic [tot_pkg::TAG_W-1:0]          handler_tag,
	input  logic [tot_pkg::ATTR_W-1:0]         handler_attr,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               status,
	output logic                               running,
	output logic signed [tot_pkg::TIME_W-1:0]  remaining,
	output logic                               expired,
	output logic [tot_pkg::CUR_W-1:0]          expired_task,
	output logic [tot_pkg::TAG_W-1:0]          expired_handler
);
	import tot_pkg::*;

	logic              accept;
	logic              adv;
	logic              commit;
	logic [ID_W-1:0]   rid;
	logic              rid_ok;
	logic [ID_W-1:0]   rd_addr;

	logic              vld_s1;
	logic [ACT_W-1:0]  action_s1;
	logic              ok_s1;
	logic [ID_W-1:0]   idx_s1;
	logic [TVAL_W-1:0] time_value_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic [ATTR_W-1:0] attr_s1;

	entry_wr_t         wr;
	entry_rd_t         rd;

	logic              st_nx;
	logic              run_nx;
	logic [TIME_W-1:0] rem_nx;
	logic              exp_nx;
	logic [CUR_W-1:0]  exp_task_nx;
	logic [TAG_W-1:0]  exp_hnd_nx;
	logic [TIME_W-1:0] cur_time;
	logic [TIME_W-1:0] new_time;
	logic              time_we;
	logic              hnd_we;
	logic              run_set;
	logic              run_clr;

	// advance the compute stage when the output register is free
	assign adv      = !out_valid || out_ready;
	assign in_ready = !vld_s1 || adv;
	assign accept   = in_valid && in_ready;
	assign commit   = vld_s1 && adv;

	// resolve the target task; define and tick always use the current task
	always_comb begin
		if ((action == ACT_DEFINE) || (action == ACT_TICK) || (task_id == '0)) begin
			rid = {1'b0, current_task};
		end else begin
			rid = task_id;
		end
		rid_ok  = (rid != '0) && (rid <= ID_W'(MAX_TASKS));
		rd_addr = rid_ok ? rid : '0;
	end

	// hold the accepted beat for the compute stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1     <= action;
			ok_s1         <= rid_ok;
			idx_s1        <= rd_addr;
			time_value_s1 <= time_value;
			tag_s1        <= handler_tag;
			attr_s1       <= handler_attr;
		end
	end

	tot_entry_store #(
		.MAX_TASKS (MAX_TASKS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.wr      (wr),
		.rd      (rd)
	);

	// apply the action to the entry and form the result
	always_comb begin
		cur_time    = rd.time_vld ? rd.time_rd : '0;
		new_time    = cur_time - {1'b0, time_value_s1};
		st_nx       = STATUS_OK;
		run_nx      = 1'b0;
		rem_nx      = '0;
		exp_nx      = 1'b0;
		exp_task_nx = '0;
		exp_hnd_nx  = '0;
		time_we     = 1'b0;
		hnd_we      = 1'b0;
		run_set     = 1'b0;
		run_clr     = 1'b0;
		case (action_s1)
			ACT_DEFINE, ACT_START, ACT_STOP, ACT_REFER, ACT_TICK: begin
				if (!ok_s1) begin
					st_nx = STATUS_BAD_ID;
				end else begin
					case (action_s1)
						ACT_DEFINE: begin
							hnd_we = 1'b1;
						end
						ACT_START: begin
							time_we = 1'b1;
							run_set = 1'b1;
						end
						ACT_STOP: begin
							run_clr = 1'b1;
						end
						ACT_REFER: begin
							run_nx = rd.run;
							rem_nx = cur_time;
						end
						default: begin
							if (rd.run) begin
								time_we = 1'b1;
								if (new_time[TIME_W-1]) begin
									run_clr     = 1'b1;
									exp_nx      = 1'b1;
									exp_task_nx = idx_s1[CUR_W-1:0];
									exp_hnd_nx  = rd.hnd_vld ? rd.tag_rd : '0;
								end
							end
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// drive the entry update only when the beat leaves the compute stage
	always_comb begin
		wr.addr    = idx_s1;
		wr.time_we = commit && time_we;
		wr.time_wd = (action_s1 == ACT_START) ? {1'b0, time_value_s1} : new_time;
		wr.hnd_we  = commit && hnd_we;
		wr.tag_wd  = tag_s1;
		wr.attr_wd = (tag_s1 == '0) ? '0 : attr_s1;
		wr.run_set = commit && run_set;
		wr.run_clr = commit && run_clr;
	end

	// hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status          <= st_nx;
			running         <= run_nx;
			remaining       <= $signed(rem_nx);
			expired         <= exp_nx;
			expired_task    <= exp_task_nx;
			expired_handler <= exp_hnd_nx;
		end
	end

endmodule

>>> src/tot_entry_store.sv
// ----------------------------------------------------------------------------
// tot_entry_store: per-task timer and handler storage
//
// Time and handler words sit in memories with a registered read port that
// takes the address of an accepted beat. A write to the same entry in the
// same cycle is forwarded into the read register. Run flags and per-entry
// valid bits are flip-flops cleared by reset and are presented with the
// entry, so that the table can treat an entry that is not valid as zero.
// ----------------------------------------------------------------------------
module tot_entry_store #(
	parameter int MAX_TASKS = tot_pkg::MAX_TASKS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [tot_pkg::ID_W-1:0]  rd_addr,
	input  tot_pkg::entry_wr_t        wr,
	output tot_pkg::entry_rd_t        rd
);
	import tot_pkg::*;

	localparam int DEPTH = MAX_TASKS + 1;
	localparam int IDX_W = $clog2(DEPTH);

	logic [TIME_W-1:0]       time_mem [DEPTH];
	logic [TAG_W+ATTR_W-1:0] hnd_mem  [DEPTH];
	logic [DEPTH-1:0]        run_q;
	logic [DEPTH-1:0]        time_vld_q;
	logic [DEPTH-1:0]        hnd_vld_q;
	logic [TIME_W-1:0]       time_rd_q;
	logic [TAG_W+ATTR_W-1:0] hnd_rd_q;
	logic [IDX_W-1:0]        ra;
	logic [IDX_W-1:0]        wa;
	logic [TAG_W+ATTR_W-1:0] hnd_wd;

	assign ra     = rd_addr[IDX_W-1:0];
	assign wa     = wr.addr[IDX_W-1:0];
	assign hnd_wd = {wr.attr_wd, wr.tag_wd};

	// write the time memory, read with forwarding of a same-entry write
	always_ff @(posedge clk) begin
		if (wr.time_we) begin
			time_mem[wa] <= wr.time_wd;
		end
		if (rd_en) begin
			if (wr.time_we && (wa == ra)) begin
				time_rd_q <= wr.time_wd;
			end else begin
				time_rd_q <= time_mem[ra];
			end
		end
	end

	// write the handler memory, read with forwarding of a same-entry write
	always_ff @(posedge clk) begin
		if (wr.hnd_we) begin
			hnd_mem[wa] <= hnd_wd;
		end
		if (rd_en) begin
			if (wr.hnd_we && (wa == ra)) begin
				hnd_rd_q <= hnd_wd;
			end else begin
				hnd_rd_q <= hnd_mem[ra];
			end
		end
	end

	// track run flags and entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= '0;
			time_vld_q <= '0;
			hnd_vld_q  <= '0;
		end else begin
			if (wr.run_set) begin
				run_q[wa] <= 1'b1;
			end else if (wr.run_clr) begin
				run_q[wa] <= 1'b0;
			end
			if (wr.time_we) begin
				time_vld_q[wa] <= 1'b1;
			end
			if (wr.hnd_we) begin
				hnd_vld_q[wa] <= 1'b1;
			end
		end
	end

	// present the entry at the compute stage address
	always_comb begin
		rd.run      = run_q[wa];
		rd.time_vld = time_vld_q[wa];
		rd.time_rd  = time_rd_q;
		rd.hnd_vld  = hnd_vld_q[wa];
		rd.tag_rd   = hnd_rd_q[TAG_W-1:0];
		rd.attr_rd  = hnd_rd_q[TAG_W+ATTR_W-1:TAG_W];
	end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for task_overrun_timer_table
//
// Drives define, start, stop, refer and tick beats, including bad ids and
// unknown actions, with random gaps on the input and random stalls on the
// output. A scoreboard keeps its own copy of the per-task timer table. It
// works out the expected result beat for every accepted action and compares
// each result beat, field by field, against the oldest one still due.
// ----------------------------------------------------------------------------

typedef struct {
	logic [tot_pkg::ACT_W-1:0]  action;
	logic [tot_pkg::ID_W-1:0]   task_id;
	logic [tot_pkg::CUR_W-1:0]  current_task;
	logic [tot_pkg::TVAL_W-1:0] time_value;
	logic [tot_pkg::TAG_W-1:0]  handler_tag;
	logic [tot_pkg::ATTR_W-1:0] handler_attr;
} overrun_cmd_t;

typedef struct {
	logic                             status;
	logic                             running;
	logic signed [tot_pkg::TIME_W-1:0] remaining;
	logic                             expired;
	logic [tot_pkg::CUR_W-1:0]        expired_task;
	logic [tot_pkg::TAG_W-1:0]        expired_handler;
} overrun_result_t;

class overrun_board;
	localparam int TASKS = tot_pkg::MAX_TASKS_DEF;

	bit                         run_flag [TASKS+1];
	longint                     time_left [TASKS+1];
	logic [tot_pkg::TAG_W-1:0]  tag_store [TASKS+1];
	logic [tot_pkg::ATTR_W-1:0] attr_store [TASKS+1];
	overrun_result_t            due_results [$];
	int                         errors;
	int                         beats;

	function new();
		for (int i = 0; i <= TASKS; i++) begin
			run_flag[i] = 1'b0;
			time_left[i] = 0;
			tag_store[i] = '0;
			attr_store[i] = '0;
		end
		errors = 0;
		beats = 0;
	endfunction

	task report(string msg);
		$display("[%0t] mismatch at result beat %0d: %s", $time, beats, msg);
		errors++;
	endtask

	// Apply one accepted action to the table copy and queue its result beat
	function void note_action(overrun_cmd_t cmd);
		overrun_result_t want;
		logic [tot_pkg::ID_W-1:0] id;
		want = '{default: '0};
		want.status = tot_pkg::STATUS_OK;
		if (cmd.action > tot_pkg::ACT_TICK) begin
			due_results.push_back(want);
			return;
		end
		// define and tick always act on the running task
		if (cmd.action == tot_pkg::ACT_DEFINE || cmd.action == tot_pkg::ACT_TICK ||
			cmd.task_id == '0)
			id = {1'b0, cmd.current_task};
		else
			id = cmd.task_id;
		if (id == '0 || id > TASKS) begin
			want.status = tot_pkg::STATUS_BAD_ID;
		end else begin
			case (cmd.action)
				tot_pkg::ACT_DEFINE: begin
					tag_store[id] = cmd.handler_tag;
					attr_store[id] = (cmd.handler_tag == '0) ? '0 : cmd.handler_attr;
				end
				tot_pkg::ACT_START: begin
					time_left[id] = longint'(cmd.time_value);
					run_flag[id] = 1'b1;
				end
				tot_pkg::ACT_STOP: begin
					run_flag[id] = 1'b0;
				end
				tot_pkg::ACT_REFER: begin
					want.running = run_flag[id];
					want.remaining = time_left[id][31:0];
				end
				default: begin
					// tick: count down a running timer, fire once it drops below zero
					if (run_flag[id]) begin
						time_left[id] -= longint'(cmd.time_value);
						if (time_left[id] < 0) begin
							run_flag[id] = 1'b0;
							want.expired = 1'b1;
							want.expired_task = id[tot_pkg::CUR_W-1:0];
							want.expired_handler = tag_store[id];
						end
					end
				end
			endcase
		end
		due_results.push_back(want);
	endfunction

	// Compare one result beat against the oldest expectation
	task check_beat(overrun_result_t got);
		overrun_result_t want;
		beats++;
		if (due_results.size() == 0) begin
			report("result beat with nothing due");
			return;
		end
		want = due_results.pop_front();
		if (got.status !== want.status)
			report($sformatf("status %0b, want %0b", got.status, want.status));
		if (got.running !== want.running)
			report($sformatf("running %0b, want %0b", got.running, want.running));
		if (got.remaining !== want.remaining)
			report($sformatf("remaining %0d, want %0d", got.remaining, want.remaining));
		if (got.expired !== want.expired)
			report($sformatf("expired %0b, want %0b", got.expired, want.expired));
		if (got.expired_task !== want.expired_task)
			report($sformatf("expired_task %0d, want %0d", got.expired_task,
				want.expired_task));
		if (got.expired_handler !== want.expired_handler)
			report($sformatf("expired_handler %h, want %h", got.expired_handler,
				want.expired_handler));
	endtask
endclass

module tb;
	localparam int RANDOM_ITEMS = 650;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 12;
	localparam logic [tot_pkg::TVAL_W-1:0] TIME_MAX = '1;

	logic                               clk;
	logic                               arst_n = 1'b0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic [tot_pkg::ACT_W-1:0]          action = '0;
	logic [tot_pkg::ID_W-1:0]           task_id = '0;
	logic [tot_pkg::CUR_W-1:0]          current_task = '0;
	logic [tot_pkg::TVAL_W-1:0]         time_value = '0;
	logic [tot_pkg::TAG_W-1:0]          handler_tag = '0;
	logic [tot_pkg::ATTR_W-1:0]         handler_attr = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic                               status;
	logic                               running;
	logic signed [tot_pkg::TIME_W-1:0]  remaining;
	logic                               expired;
	logic [tot_pkg::CUR_W-1:0]          expired_task;
	logic [tot_pkg::TAG_W-1:0]          expired_handler;

	overrun_board board;
	int           issued = 0;
	int           cycle_count = 0;
	bit           steady = 1'b0;

	task_overrun_timer_table dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.task_id        (task_id),
		.current_task   (current_task),
		.time_value     (time_value),
		.handler_tag    (handler_tag),
		.handler_attr   (handler_attr),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.running        (running),
		.remaining      (remaining),
		.expired        (expired),
		.expired_task   (expired_task),
		.expired_handler(expired_handler)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic overrun_cmd_t make_cmd(
		input logic [tot_pkg::ACT_W-1:0]  act,
		input logic [tot_pkg::ID_W-1:0]   tid,
		input logic [tot_pkg::CUR_W-1:0]  cur,
		input logic [tot_pkg::TVAL_W-1:0] tval,
		input logic [tot_pkg::TAG_W-1:0]  tag,
		input logic [tot_pkg::ATTR_W-1:0] attr
	);
		overrun_cmd_t cmd;
		cmd.action = act;
		cmd.task_id = tid;
		cmd.current_task = cur;
		cmd.time_value = tval;
		cmd.handler_tag = tag;
		cmd.handler_attr = attr;
		return cmd;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// Hold one beat on the input until accepted, then maybe idle
	task automatic issue(input overrun_cmd_t cmd);
		int gap;
		action <= cmd.action;
		task_id <= cmd.task_id;
		current_task <= cmd.current_task;
		time_value <= cmd.time_value;
		handler_tag <= cmd.handler_tag;
		handler_attr <= cmd.handler_attr;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		issued++;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic issue_noise();
		issue(make_cmd(3'($urandom), 8'($urandom), 7'($urandom), 31'($urandom),
			$urandom, 16'($urandom)));
	endtask

	// Refer to a task either by its id or as the running task
	task automatic issue_refer(input logic [tot_pkg::CUR_W-1:0] t);
		if ($urandom_range(0, 1) == 0)
			issue(make_cmd(tot_pkg::ACT_REFER, 8'd0, t, 31'($urandom), $urandom,
				16'($urandom)));
		else
			issue(make_cmd(tot_pkg::ACT_REFER, {1'b0, t}, 7'($urandom_range(1, 64)),
				31'($urandom), $urandom, 16'($urandom)));
	endtask

	// One timer's life: optional define, start, a run of ticks mixed with refers, stops and stray ticks, final refer
	task automatic run_sequence();
		logic [tot_pkg::CUR_W-1:0]  t;
		logic [tot_pkg::TVAL_W-1:0] limit;
		logic [tot_pkg::TVAL_W-1:0] delta;
		logic [tot_pkg::TAG_W-1:0]  tag;
		longint                     left;
		int                         r;
		t = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(1, 64)) : 7'($urandom_range(1, 8));
		if ($urandom_range(0, 2) == 0) begin
			tag = ($urandom_range(0, 4) == 0) ? '0 : $urandom;
			issue(make_cmd(tot_pkg::ACT_DEFINE, 8'($urandom), t, 31'($urandom), tag,
				16'($urandom)));
		end
		r = $urandom_range(0, 9);
		if (r < 5)
			limit = 31'($urandom_range(0, 200));
		else if (r < 8)
			limit = 31'($urandom_range(0, 100000));
		else if (r < 9)
			limit = 31'($urandom);
		else
			limit = TIME_MAX;
		left = longint'(limit);
		if ($urandom_range(0, 1) == 0)
			issue(make_cmd(tot_pkg::ACT_START, 8'd0, t, limit, $urandom, 16'($urandom)));
		else
			issue(make_cmd(tot_pkg::ACT_START, {1'b0, t}, 7'($urandom), limit, $urandom,
				16'($urandom)));
		repeat ($urandom_range(1, 6)) begin
			r = $urandom_range(0, 19);
			if (r < 4)
				issue_refer(t);
			else if (r < 6)
				issue(make_cmd(tot_pkg::ACT_STOP, {1'b0, t}, 7'($urandom), 31'($urandom),
					$urandom, 16'($urandom)));
			else if (r < 8)
				issue(make_cmd(tot_pkg::ACT_TICK, 8'($urandom), 7'($urandom_range(1, 64)),
					31'($urandom_range(0, 300)), $urandom, 16'($urandom)));
			// land exactly on zero or one past it now and then
			r = $urandom_range(0, 5);
			if (r == 0 && left >= 0)
				delta = left[30:0];
			else if (r == 1 && left >= 0 && left < longint'(TIME_MAX))
				delta = 31'(left + 1);
			else
				delta = 31'($urandom_range(0, 32'(limit / 2) + 2));
			left -= longint'(delta);
			issue(make_cmd(tot_pkg::ACT_TICK, 8'($urandom), t, delta, $urandom,
				16'($urandom)));
		end
		issue_refer(t);
	endtask

	// Result side: stall at random, with stretches of steady flow
	initial begin
		int n;
		@(posedge clk iff arst_n);
		forever begin
			n = steady ? 0 : pick_gap();
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Watch both channels; results come first since they trail the inputs
	always @(posedge clk) begin
		overrun_result_t got;
		if (out_valid && out_ready) begin
			got.status = status;
			got.running = running;
			got.remaining = remaining;
			got.expired = expired;
			got.expired_task = expired_task;
			got.expired_handler = expired_handler;
			board.check_beat(got);
		end
		if (in_valid && in_ready)
			board.note_action(make_cmd(action, task_id, current_task, time_value,
				handler_tag, handler_attr));
	end

	// Give up on a hang
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("task_overrun_timer_table test failed");
		$finish;
	end

	initial begin
		int base;
		board = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fresh entry reads stopped with zero time
		issue(make_cmd(tot_pkg::ACT_REFER, 8'd1, 7'd5, '0, '0, '0));
		// Full handler on task 1, cancel on task 2
		issue(make_cmd(tot_pkg::ACT_DEFINE, 8'd0, 7'd1, '0, '1, '1));
		issue(make_cmd(tot_pkg::ACT_DEFINE, 8'd0, 7'd2, '0, '0, '1));
		// Largest limit, count it down to zero, then one past
		issue(make_cmd(tot_pkg::ACT_START, 8'd1, 7'd9, TIME_MAX, '0, '0));
		issue(make_cmd(tot_pkg::ACT_REFER, 8'd1, 7'd9, '0, '0, '0));
		issue(make_cmd(tot_pkg::ACT_TICK, 8'd0, 7'd1, TIME_MAX, '0, '0));
		issue(make_cmd(tot_pkg::ACT_TICK, 8'd0, 7'd1, '0, '0, '0));
		issue(make_cmd(tot_pkg::ACT_TICK, 8'd0, 7'd1, 31'd1, '0, '0));
		issue(make_cmd(tot_pkg::ACT_REFER, 8'd0, 7'd1, '0, '0, '0));
		// Self selection on the top task; overrun with no handler, deepest time
		issue(make_cmd(tot_pkg::ACT_START, 8'd0, 7'd64, '0, '0, '0));
		issue(make_cmd(tot_pkg::ACT_TICK, 8'd0, 7'd64, TIME_MAX, '0, '0));
		issue(make_cmd(tot_pkg::ACT_REFER, 8'd64, 7'd1, '0, '0, '0));
		// Stopped timer ignores ticks
		issue(make_cmd(tot_pkg::ACT_START, 8'd2, 7'd1, 31'd100, '0, '0));
		issue(make_cmd(tot_pkg::ACT_STOP, 8'd0, 7'd2, '0, '0, '0));
		issue(make_cmd(tot_pkg::ACT_TICK, 8'd0, 7'd2, 31'd200, '0, '0));
		issue(make_cmd(tot_pkg::ACT_REFER, 8'd2, 7'd1, '0, '0, '0));
		// Bad ids on every action
		issue(make_cmd(tot_pkg::ACT_START, 8'd65, 7'd1, 31'd7, '0, '0));
		issue(make_cmd(tot_pkg::ACT_REFER, 8'd255, 7'd1, '0, '0, '0));
		issue(make_cmd(tot_pkg::ACT_DEFINE, 8'd0, 7'd0, '0, '1, '1));
		issue(make_cmd(tot_pkg::ACT_TICK, 8'd0, 7'd127, 31'd1, '0, '0));
		issue(make_cmd(tot_pkg::ACT_STOP, 8'd0, 7'd0, '0, '0, '0));
		// Unknown actions with every field high
		issue(make_cmd(3'd5, '1, '1, '1, '1, '1));
		issue(make_cmd(3'd7, '1, '1, '1, '1, '1));
		// Cancel a live handler, then overrun reports no handler
		issue(make_cmd(tot_pkg::ACT_DEFINE, 8'd0, 7'd1, '0, '0, '1));
		issue(make_cmd(tot_pkg::ACT_START, 8'd0, 7'd1, 31'd5, '0, '0));
		issue(make_cmd(tot_pkg::ACT_TICK, 8'd0, 7'd1, 31'd6, '0, '0));

		// Mostly well-formed timer lives, some noise
		base = issued;
		while (issued - base < RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 6) == 0);
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) issue_noise();
			else
				run_sequence();
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		// Drain what is still due, then watch for stray beats
		do
			@(posedge clk);
		while (board.due_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.due_results.size() == 0)
			$display("task_overrun_timer_table test passed");
		else
			$display("task_overrun_timer_table test failed");
		$finish;
	end
endmodule

>>> files.f
src/tot_pkg.sv
src/tot_entry_store.sv
src/task_overrun_timer_table.sv
bench/tb.sv
